[hdl/nqueens_subtree_counter_core_assert.svh]
// ----------------------------------------------------------------------------
// N-queens subtree counter: assertion macros
// Shared property forms for the checker. Each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef NQUEENS_SUBTREE_COUNTER_CORE_ASSERT_SVH
`define NQUEENS_SUBTREE_COUNTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NQSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("nqsc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NQSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("nqsc assertion failed");

`endif

[hdl/nqsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens subtree counter package
// Field widths, defaults and reset values shared by the counter files.
// ----------------------------------------------------------------------------
package nqsc_pkg;

    // Default board capacity and count width.
    localparam int MAX_SIZE    = 21;
    localparam int COUNT_WIDTH = 40;

    // Fixed widths of the external fields.
    localparam int CFG_W         = 5;
    localparam int ROW_FIELD_W   = 5;
    localparam int MASK_FIELD_W  = 21;
    localparam int COUNT_FIELD_W = 40;

    // Board width after reset.
    localparam logic [CFG_W-1:0] BOARD_SIZE_RESET = 5'd8;

endpackage

[hdl/nqsc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens subtree counter channels
// Valid/ready channels for task words in and count words out.
// ----------------------------------------------------------------------------

// Task channel: one partial placement per word.
interface nqsc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [nqsc_pkg::ROW_FIELD_W-1:0]      start_row;
    logic [nqsc_pkg::MASK_FIELD_W-1:0]     column_mask;
    logic [nqsc_pkg::MASK_FIELD_W-1:0]     right_diag_mask;
    logic [nqsc_pkg::MASK_FIELD_W-1:0]     left_diag_mask;

    modport source (
        output valid, start_row, column_mask, right_diag_mask, left_diag_mask,
        input  ready
    );
    modport sink (
        input  valid, start_row, column_mask, right_diag_mask, left_diag_mask,
        output ready
    );
endinterface

// Result channel: one doubled completion count per word.
interface nqsc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [nqsc_pkg::COUNT_FIELD_W-1:0]    solution_count;

    modport source (
        output valid, solution_count,
        input  ready
    );
    modport sink (
        input  valid, solution_count,
        output ready
    );
endinterface

[hdl/nqsc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens subtree counter RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module nqsc_ram #(
    parameter int WIDTH = 84,
    parameter int DEPTH = 21
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/nqueens_subtree_counter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens subtree counter
// Counts all completions of one partial placement by depth-first search.
// ----------------------------------------------------------------------------
// The core takes one task word (a row and its column, right- and left-diagonal
// attack masks) and returns one word holding twice the number of complete
// placements below it, saturating at the count maximum. It works on one task
// at a time: the input is ready only while the search engine is idle. The
// search visits one tree node per cycle except while it backtracks, when the
// parent row is read back from the stack RAM through its registered read
// port. The stack RAM needs no clearing after reset. A finished count waits
// in the output register, so the next task is accepted while it is still
// pending. The user must write the board width register only while the core
// is idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module nqueens_subtree_counter_core #(
    parameter int MAX_SIZE    = nqsc_pkg::MAX_SIZE,
    parameter int COUNT_WIDTH = nqsc_pkg::COUNT_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [nqsc_pkg::CFG_W-1:0]  i_cfg_wr_data,
    nqsc_in_if.sink                     i_in,
    nqsc_out_if.source                  o_out
);

    localparam int RW    = $clog2(MAX_SIZE);
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int SW    = $clog2(MAX_SIZE);
    localparam int ENT_W = 4 * MAX_SIZE;
    localparam int MFW   = nqsc_pkg::MASK_FIELD_W;
    localparam int OFW   = nqsc_pkg::COUNT_FIELD_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_STEP   = 4'b0010,
        S_POP    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [nqsc_pkg::CFG_W-1:0]   r_board_size;
    logic [RW-1:0]                r_row, n_row;
    logic [RW-1:0]                r_last, n_last;
    logic [SW-1:0]                r_sp, n_sp;
    logic [MAX_SIZE-1:0]          r_full, n_full;
    logic [MAX_SIZE-1:0]          r_cand, n_cand;
    logic [MAX_SIZE-1:0]          r_col, n_col;
    logic [MAX_SIZE-1:0]          r_rd, n_rd;
    logic [MAX_SIZE-1:0]          r_ld, n_ld;
    logic [COUNT_WIDTH-1:0]       r_found, n_found;
    logic                         r_out_valid, n_out_valid;
    logic [OFW-1:0]               r_out_count, n_out_count;

    logic                         in_accept;
    logic                         size_over;
    logic [NW-1:0]                board_n;
    logic [MAX_SIZE-1:0]          full_mask;
    logic [RW-1:0]                last_row;
    logic [RW-1:0]                first_row;
    logic [MAX_SIZE+MFW-1:0]      ext_col, ext_rd, ext_ld;
    logic [MAX_SIZE-1:0]          in_col, in_rd, in_ld;
    logic [MAX_SIZE-1:0]          cand_low, cand_rest;
    logic [MAX_SIZE-1:0]          child_col, child_rd, child_ld;
    logic [COUNT_WIDTH-1:0]       found_inc;
    logic [COUNT_WIDTH-1:0]       result_full;
    logic [COUNT_WIDTH+OFW-1:0]   result_ext;

    logic                         ram_wr_en;
    logic                         ram_rd_en;
    logic [SW-1:0]                ram_rd_addr;
    logic [ENT_W-1:0]             ram_wr_data;
    logic [ENT_W-1:0]             ram_rd_data;

    // Handshakes.
    assign i_in.ready           = (r_state == S_IDLE);
    assign in_accept            = i_in.valid && (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.solution_count = r_out_count;

    // Board geometry from the width register, clamped to the capacity.
    assign size_over = (32'(r_board_size) > 32'(MAX_SIZE));
    assign board_n   = size_over ? NW'(MAX_SIZE) : NW'(r_board_size);
    assign full_mask = ~({MAX_SIZE{1'b1}} << board_n);
    assign last_row  = RW'(board_n - NW'(1));
    assign first_row = (32'(i_in.start_row) > 32'(last_row)) ?
                       last_row : RW'(i_in.start_row);

    // Task masks resized to the board capacity and trimmed to the board.
    assign ext_col = {{MAX_SIZE{1'b0}}, i_in.column_mask};
    assign ext_rd  = {{MAX_SIZE{1'b0}}, i_in.right_diag_mask};
    assign ext_ld  = {{MAX_SIZE{1'b0}}, i_in.left_diag_mask};
    assign in_col  = ext_col[MAX_SIZE-1:0] & full_mask;
    assign in_rd   = ext_rd[MAX_SIZE-1:0] & full_mask;
    assign in_ld   = ext_ld[MAX_SIZE-1:0] & full_mask;

    // Lowest free position and the attack masks of the row below.
    assign cand_low  = r_cand & (~r_cand + MAX_SIZE'(1));
    assign cand_rest = r_cand & ~cand_low;
    assign child_col = (r_col | cand_low) & r_full;
    assign child_rd  = ((r_rd | cand_low) >> 1) & r_full;
    assign child_ld  = ((r_ld | cand_low) << 1) & r_full;

    // Saturating leaf count and its doubled, saturated result.
    assign found_inc   = (r_found == {COUNT_WIDTH{1'b1}}) ?
                         r_found : r_found + COUNT_WIDTH'(1);
    assign result_full = r_found[COUNT_WIDTH-1] ? {COUNT_WIDTH{1'b1}} :
                         {r_found[COUNT_WIDTH-2:0], 1'b0};
    assign result_ext  = {{OFW{1'b0}}, result_full};

    // Stack entries hold the untried positions and the row's attack masks.
    assign ram_wr_data = {cand_rest, r_col, r_rd, r_ld};
    assign ram_rd_addr = r_sp - SW'(1);

    // Search sequencer.
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_last      = r_last;
        n_sp        = r_sp;
        n_full      = r_full;
        n_cand      = r_cand;
        n_col       = r_col;
        n_rd        = r_rd;
        n_ld        = r_ld;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_found = '0;
                    n_sp    = '0;
                    n_full  = full_mask;
                    n_last  = last_row;
                    n_row   = first_row;
                    n_col   = in_col;
                    n_rd    = in_rd;
                    n_ld    = in_ld;
                    n_cand  = full_mask & ~(in_col | in_rd | in_ld);
                    n_state = (board_n == '0) ? S_FINISH : S_STEP;
                end
            end
            S_STEP: begin
                if (r_cand != '0 && r_row != r_last) begin
                    // Place a queen and descend one row.
                    ram_wr_en = 1'b1;
                    n_sp      = r_sp + SW'(1);
                    n_row     = r_row + RW'(1);
                    n_col     = child_col;
                    n_rd      = child_rd;
                    n_ld      = child_ld;
                    n_cand    = r_full & ~(child_col | child_rd | child_ld);
                end else begin
                    // A queen on the last row is one completion.
                    if (r_cand != '0) begin
                        n_found = found_inc;
                    end
                    if (r_sp == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        ram_rd_en = 1'b1;
                        n_sp      = ram_rd_addr;
                        n_row     = r_row - RW'(1);
                        n_state   = S_POP;
                    end
                end
            end
            S_POP: begin
                // Restore the parent row from the stack.
                n_cand  = ram_rd_data[4*MAX_SIZE-1:3*MAX_SIZE];
                n_col   = ram_rd_data[3*MAX_SIZE-1:2*MAX_SIZE];
                n_rd    = ram_rd_data[2*MAX_SIZE-1:MAX_SIZE];
                n_ld    = ram_rd_data[MAX_SIZE-1:0];
                n_state = S_STEP;
            end
            S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_count = result_ext[OFW-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_board_size <= nqsc_pkg::BOARD_SIZE_RESET;
            r_row        <= '0;
            r_sp         <= '0;
            r_cand       <= '0;
            r_found      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_row       <= n_row;
            r_sp        <= n_sp;
            r_cand      <= n_cand;
            r_found     <= n_found;
            if (i_cfg_wr_en) begin
                r_board_size <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_last      <= n_last;
        r_full      <= n_full;
        r_col       <= n_col;
        r_rd        <= n_rd;
        r_ld        <= n_ld;
        r_out_count <= n_out_count;
    end

    // Backtracking stack.
    nqsc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SIZE)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_sp),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule

[hdl/nqsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens subtree counter checker
// Port-level checks on task and count word flow, bound to the core.
// ----------------------------------------------------------------------------
`include "nqueens_subtree_counter_core_assert.svh"

module nqsc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [nqsc_pkg::COUNT_FIELD_W-1:0]  i_out_count
);

    // A stalled count word stays put.
    `NQSC_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_count))

    // Once a task word is taken, the core is busy in the next cycle.
    `NQSC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // An idle core stays ready while no task word arrives.
    `NQSC_ASSERT_NEXT(a_idle_holds, i_in_ready && !i_in_valid, i_in_ready)

    // A new count word only appears at the end of a search.
    `NQSC_ASSERT_SAME(a_count_after_search, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind nqueens_subtree_counter_core nqsc_checker u_nqsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_count (o_out.solution_count)
);
